// ----- rtl/core/slpli_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Status line LED indicator package
// Shared types, status codes, prefix texts and color table.
// ----------------------------------------------------------------------------
package slpli_pkg;

  localparam int unsigned LineStore = 24;
  localparam int unsigned LenW      = $clog2(LineStore + 1);
  localparam int unsigned NumPat    = 8;
  localparam int unsigned PatMax    = 20;
  localparam int unsigned PatIdxW   = $clog2(PatMax);
  localparam int unsigned TimeW     = 32;
  localparam int unsigned CfgW      = 16;
  localparam int unsigned ColorW    = 24;

  typedef enum logic [3:0] {
    ST_CONNECT = 4'd0,
    ST_IDLE    = 4'd1,
    ST_RUN     = 4'd2,
    ST_HOLD    = 4'd3,
    ST_JOG     = 4'd4,
    ST_DOOR    = 4'd5,
    ST_HOME    = 4'd6,
    ST_ALARM   = 4'd7,
    ST_NONE    = 4'd8
  } status_e;

  typedef enum logic {
    REQ_BYTE = 1'b0,
    REQ_TICK = 1'b1
  } req_type_e;

  typedef enum logic {
    CFG_BLINK_INTERVAL  = 1'b0,
    CFG_REQUEST_TIMEOUT = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic       strobe;
    logic [7:0] data;
  } byte_evt_t;

  typedef logic [PatMax-1:0][7:0] pat_text_t;

  localparam logic [7:0] CharLf = 8'h0a;
  localparam logic [7:0] CharCr = 8'h0d;

  localparam pat_text_t PAT_TEXT [NumPat] = '{
    "[MSG:INFO: Connected", "<Idle", "<Run", "<Hold",
    "<Jog", "<Door", "<Home", "<Alarm"
  };

  localparam logic [LenW-1:0] PAT_LEN [NumPat] = '{
    LenW'(20), LenW'(5), LenW'(4), LenW'(5),
    LenW'(4), LenW'(5), LenW'(5), LenW'(6)
  };

  localparam logic [ColorW-1:0] ColorRed    = 24'hff0000;
  localparam logic [ColorW-1:0] ColorPurple = 24'hff00ff;

  localparam logic [ColorW-1:0] STATUS_COLOR [NumPat] = '{
    24'h00ff00, 24'h00ff00, 24'h007fff, 24'hffcf00,
    24'hff00ff, 24'hff5f00, 24'hff00ff, 24'hff0000
  };

  localparam logic [CfgW-1:0] BlinkReset   = 16'd250;
  localparam logic [CfgW-1:0] TimeoutReset = 16'd5000;

endpackage

// ----- rtl/core/slpli_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Status line LED indicator channels
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface slpli_in_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] rx_byte;

  modport source (output valid, req_type, rx_byte, input ready);
  modport sink   (input valid, req_type, rx_byte, output ready);
endinterface

interface slpli_out_if;
  logic        valid;
  logic        ready;
  logic [23:0] led_color;
  logic        led_changed;
  logic        send_request;
  logic [3:0]  line_status;

  modport source (output valid, led_color, led_changed, send_request, line_status,
                  input ready);
  modport sink   (input valid, led_color, led_changed, send_request, line_status,
                  output ready);
endinterface

// ----- rtl/core/slpli_match.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line prefix matcher
// Tracks the line length and one running prefix match flag per status text.
// ----------------------------------------------------------------------------
module slpli_match (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  slpli_pkg::byte_evt_t  evt_i,
  output slpli_pkg::status_e    line_status_o
);

  logic [slpli_pkg::LenW-1:0]   len_d, len_q;
  logic [slpli_pkg::NumPat-1:0] ok_d, ok_q;
  logic                         is_lf, is_cr, store;
  logic [slpli_pkg::LenW-1:0]   pos;
  logic                         found;

  assign is_lf = (evt_i.data == slpli_pkg::CharLf);
  assign is_cr = (evt_i.data == slpli_pkg::CharCr);
  assign store = evt_i.strobe && !is_lf && !is_cr &&
                 (len_q < slpli_pkg::LenW'(slpli_pkg::LineStore));

  always_comb begin
    len_d = len_q;
    ok_d  = ok_q;
    pos   = '0;
    if (evt_i.strobe && is_lf) begin
      len_d = '0;
      ok_d  = '1;
    end else if (store) begin
      len_d = len_q + slpli_pkg::LenW'(1);
      for (int s = 0; s < slpli_pkg::NumPat; s++) begin
        pos = slpli_pkg::PAT_LEN[s] - slpli_pkg::LenW'(1) - len_q;
        if (len_q < slpli_pkg::PAT_LEN[s] &&
            evt_i.data != slpli_pkg::PAT_TEXT[s][pos[slpli_pkg::PatIdxW-1:0]]) begin
          ok_d[s] = 1'b0;
        end
      end
    end
  end

  always_comb begin
    line_status_o = slpli_pkg::ST_NONE;
    found         = 1'b0;
    for (int s = 0; s < slpli_pkg::NumPat; s++) begin
      if (!found && ok_q[s] && len_q != '0 && len_q >= slpli_pkg::PAT_LEN[s]) begin
        found         = 1'b1;
        line_status_o = slpli_pkg::status_e'(4'(s));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0;
      ok_q  <= '1;
    end else begin
      len_q <= len_d;
      ok_q  <= ok_d;
    end
  end

endmodule

// ----- rtl/core/status_line_prefix_led_indicator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Status line LED indicator
// Builds text lines from received bytes, classifies them by prefix, drives
// the LED color, blinks before connect and flags status requests on ticks.
// ----------------------------------------------------------------------------
//  channel   dir   handshake        payload
//  in_ch     in    valid / ready    req_type, rx_byte
//  out_ch    out   valid / ready    led_color, led_changed, send_request,
//                                   line_status
//  cfg       in    cfg_we_i         cfg_idx_i, cfg_data_i
//
//  One item per cycle unless out_ch stalls; input register, then result register.
//  Each item gives one result, computed as it moves into the result register.
//  Reset gives red, no status, and clears the line; no clearing pass.
//  A stalled result holds; one more item waits in the input register.
// ----------------------------------------------------------------------------
module status_line_prefix_led_indicator (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  slpli_in_if.sink                   in_ch,
  slpli_out_if.source                out_ch,
  input  logic                       cfg_we_i,
  input  logic                       cfg_idx_i,
  input  logic [slpli_pkg::CfgW-1:0] cfg_data_i
);

  logic                          s1_v_q, s1_type_q;
  logic [7:0]                    s1_byte_q;
  logic                          in_acc, adv;

  logic [slpli_pkg::CfgW-1:0]    blink_q, timeout_q;

  logic                          conn_d, conn_q;
  slpli_pkg::status_e            shown_d, shown_q;
  logic [slpli_pkg::ColorW-1:0]  color_d, color_q;
  logic                          purple_d, purple_q;
  logic [slpli_pkg::TimeW-1:0]   st_age_d, st_age_q;
  logic [slpli_pkg::TimeW-1:0]   rq_age_d, rq_age_q;
  logic [slpli_pkg::TimeW-1:0]   bl_age_d, bl_age_q;
  logic [slpli_pkg::TimeW-1:0]   st_inc, rq_inc, bl_inc;

  logic                          send;
  slpli_pkg::status_e            status, match_status;
  slpli_pkg::byte_evt_t          evt;

  logic                          out_v_q;
  logic [slpli_pkg::ColorW-1:0]  o_color_q;
  logic                          o_changed_q, o_send_q;
  slpli_pkg::status_e            o_status_q;

  assign adv          = s1_v_q && (!out_v_q || out_ch.ready);
  assign in_ch.ready  = !s1_v_q || adv;
  assign in_acc       = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (in_acc) begin
      s1_v_q <= 1'b1;
    end else if (adv) begin
      s1_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_type_q <= in_ch.req_type;
      s1_byte_q <= in_ch.rx_byte;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blink_q   <= slpli_pkg::BlinkReset;
      timeout_q <= slpli_pkg::TimeoutReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        slpli_pkg::CFG_BLINK_INTERVAL:  blink_q   <= cfg_data_i;
        slpli_pkg::CFG_REQUEST_TIMEOUT: timeout_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign evt.strobe = adv && (s1_type_q == slpli_pkg::REQ_BYTE);
  assign evt.data   = s1_byte_q;

  slpli_match u_match (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .evt_i         (evt),
    .line_status_o (match_status)
  );

  assign st_inc = st_age_q + slpli_pkg::TimeW'(1);
  assign rq_inc = rq_age_q + slpli_pkg::TimeW'(1);
  assign bl_inc = bl_age_q + slpli_pkg::TimeW'(1);

  always_comb begin
    conn_d   = conn_q;
    shown_d  = shown_q;
    color_d  = color_q;
    purple_d = purple_q;
    st_age_d = st_age_q;
    rq_age_d = rq_age_q;
    bl_age_d = bl_age_q;
    send     = 1'b0;
    status   = slpli_pkg::ST_NONE;
    if (s1_type_q == slpli_pkg::REQ_TICK) begin
      st_age_d = st_inc;
      rq_age_d = rq_inc;
      bl_age_d = bl_inc;
      if (st_inc >= slpli_pkg::TimeW'(timeout_q) &&
          rq_inc >= slpli_pkg::TimeW'(timeout_q)) begin
        send     = 1'b1;
        rq_age_d = '0;
      end
      if (!conn_q && bl_inc >= slpli_pkg::TimeW'(blink_q)) begin
        purple_d = !purple_q;
        color_d  = purple_q ? slpli_pkg::ColorRed : slpli_pkg::ColorPurple;
        bl_age_d = '0;
      end
    end else if (s1_byte_q == slpli_pkg::CharLf) begin
      status = match_status;
      if (status == slpli_pkg::ST_CONNECT) begin
        conn_d   = 1'b1;
        st_age_d = '0;
        rq_age_d = '0;
      end else if (status != slpli_pkg::ST_NONE && conn_q) begin
        st_age_d = '0;
      end
      if (status != slpli_pkg::ST_NONE &&
          (status == slpli_pkg::ST_CONNECT || conn_q) && status != shown_q) begin
        color_d = slpli_pkg::STATUS_COLOR[status[2:0]];
        shown_d = status;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      conn_q   <= 1'b0;
      shown_q  <= slpli_pkg::ST_NONE;
      color_q  <= slpli_pkg::ColorRed;
      purple_q <= 1'b0;
      st_age_q <= '0;
      rq_age_q <= '0;
      bl_age_q <= '0;
    end else if (adv) begin
      conn_q   <= conn_d;
      shown_q  <= shown_d;
      color_q  <= color_d;
      purple_q <= purple_d;
      st_age_q <= st_age_d;
      rq_age_q <= rq_age_d;
      bl_age_q <= bl_age_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (adv) begin
      out_v_q <= 1'b1;
    end else if (out_ch.ready) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      o_color_q   <= color_d;
      o_changed_q <= (color_d != color_q);
      o_send_q    <= send;
      o_status_q  <= status;
    end
  end

  assign out_ch.valid        = out_v_q;
  assign out_ch.led_color    = o_color_q;
  assign out_ch.led_changed  = o_changed_q;
  assign out_ch.send_request = o_send_q;
  assign out_ch.line_status  = o_status_q;

endmodule

// ----- rtl/core/slpli_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Status line LED indicator checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module slpli_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [23:0] led_color_i,
  input  logic        led_changed_i,
  input  logic        send_request_i,
  input  logic [3:0]  line_status_i
);

  logic [23:0] last_color_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_color_q <= slpli_pkg::ColorRed;
    end else if (out_valid_i && out_ready_i) begin
      last_color_q <= led_color_i;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(led_color_i))
    else $error("result dropped or changed while stalled");

  a_send_on_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && send_request_i |-> line_status_i == slpli_pkg::ST_NONE)
    else $error("status request flagged on a line end");

  a_changed_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> led_changed_i == (led_color_i != last_color_q))
    else $error("led_changed disagrees with color sequence");

  a_change_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && led_changed_i && line_status_i == slpli_pkg::ST_NONE |->
      (led_color_i == slpli_pkg::ColorRed || led_color_i == slpli_pkg::ColorPurple))
    else $error("color changed without a status line or blink");

endmodule

bind status_line_prefix_led_indicator slpli_checker u_slpli_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (out_ch.valid),
  .out_ready_i    (out_ch.ready),
  .led_color_i    (out_ch.led_color),
  .led_changed_i  (out_ch.led_changed),
  .send_request_i (out_ch.send_request),
  .line_status_i  (out_ch.line_status)
);
